// File: design/trcpu_pkg.sv
// Shared types and constants for the two-register CPU core.
// Instruction bit positions, memory geometry and the structs passed between modules.
// No dependencies.
`default_nettype none

package trcpu_pkg;

    // Word memory geometry (power of two, 1024 to 32768 words)
    localparam int MEM_DEPTH = 32768;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);

    // Instruction field positions
    localparam int INS_COMPUTE = 15;
    localparam int INS_USE_MEM = 12;
    localparam int INS_ZX      = 11;
    localparam int INS_NX      = 10;
    localparam int INS_ZY      = 9;
    localparam int INS_NY      = 8;
    localparam int INS_F       = 7;
    localparam int INS_NO      = 6;
    localparam int INS_DEST_A  = 5;
    localparam int INS_DEST_D  = 4;
    localparam int INS_DEST_M  = 3;
    localparam int INS_JLT     = 2;
    localparam int INS_JEQ     = 1;
    localparam int INS_JGT     = 0;

    // Memory write port
    typedef struct packed {
        logic              en;
        logic [MEM_AW-1:0] addr;
        logic [15:0]       data;
    } t_mem_wr;

    // Architectural update and result of one instruction
    typedef struct packed {
        logic [14:0] pc;
        logic [14:0] a;
        logic [15:0] d;
        logic        written;
        logic [14:0] waddr;
        logic [15:0] wdata;
        logic        fault;
    } t_exec_res;

endpackage

`default_nettype wire

// File: design/trcpu_word_mem.sv
// Word memory of the CPU core: one synchronous write port, one registered read port.
// Sweeps every word to zero after reset. Depends on trcpu_pkg.
`default_nettype none

module trcpu_word_mem (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_rd_en,
    input  wire logic [trcpu_pkg::MEM_AW-1:0] i_rd_addr,
    output logic [15:0]                      o_rd_data,
    input  wire trcpu_pkg::t_mem_wr          i_wr,
    output logic                             o_ready
);
    import trcpu_pkg::*;

    logic [15:0]       r_mem [MEM_DEPTH];
    logic [15:0]       r_rd_data;
    logic              r_clearing;
    logic              n_clearing;
    logic [MEM_AW-1:0] r_clr_addr;
    logic [MEM_AW-1:0] n_clr_addr;
    logic              w_en;
    logic [MEM_AW-1:0] w_addr;
    logic [15:0]       w_data;

    // Advance the clearing sweep, one word a cycle
    always_comb begin
        n_clearing = r_clearing;
        n_clr_addr = r_clr_addr;
        if (r_clearing) begin
            n_clr_addr = r_clr_addr + {{(MEM_AW-1){1'b0}}, 1'b1};
            if (r_clr_addr == {MEM_AW{1'b1}}) begin
                n_clearing = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            r_clearing <= n_clearing;
            r_clr_addr <= n_clr_addr;
        end
    end

    // Select the sweep or the core's store
    always_comb begin
        if (r_clearing) begin
            w_en   = 1'b1;
            w_addr = r_clr_addr;
            w_data = '0;
        end else begin
            w_en   = i_wr.en;
            w_addr = i_wr.addr;
            w_data = i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mem[w_addr] <= w_data;
        end
    end

    // Hold read data until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_ready   = ~r_clearing;

endmodule

`default_nettype wire

// File: design/trcpu_exec.sv
// Execute logic of the CPU core: operand select, six-flag ALU, destinations and jump.
// Combinational; depends on trcpu_pkg.
`default_nettype none

module trcpu_exec (
    input  wire logic [15:0]          i_ins,
    input  wire logic [14:0]          i_pc,
    input  wire logic [14:0]          i_a,
    input  wire logic [15:0]          i_d,
    input  wire logic [15:0]          i_mem_data,
    output trcpu_pkg::t_exec_res      o_res
);
    import trcpu_pkg::*;

    logic [15:0] w_x;
    logic [15:0] w_y;
    logic [15:0] w_x1;
    logic [15:0] w_y1;
    logic [15:0] w_f;
    logic [15:0] w_r;
    logic        w_neg;
    logic        w_zero;
    logic        w_take;
    logic [14:0] w_a_new;
    logic [14:0] w_pc_inc;

    // ALU: zero and invert each operand, add or and, invert the result
    always_comb begin
        w_x  = i_ins[INS_ZX] ? 16'd0 : i_d;
        w_x1 = i_ins[INS_NX] ? ~w_x : w_x;
        w_y  = i_ins[INS_USE_MEM] ? i_mem_data : {1'b0, i_a};
        w_y  = i_ins[INS_ZY] ? 16'd0 : w_y;
        w_y1 = i_ins[INS_NY] ? ~w_y : w_y;
        w_f  = i_ins[INS_F] ? (w_x1 + w_y1) : (w_x1 & w_y1);
        w_r  = i_ins[INS_NO] ? ~w_f : w_f;
    end

    assign w_neg    = w_r[15];
    assign w_zero   = (w_r == 16'd0);
    assign w_take   = (i_ins[INS_JLT] & w_neg) | (i_ins[INS_JEQ] & w_zero)
                    | (i_ins[INS_JGT] & ~w_neg & ~w_zero);
    assign w_a_new  = i_ins[INS_DEST_A] ? w_r[14:0] : i_a;
    assign w_pc_inc = i_pc + 15'd1;

    // Build the update for a load-A or a compute instruction
    always_comb begin
        if (!i_ins[INS_COMPUTE]) begin
            o_res.pc      = w_pc_inc;
            o_res.a       = i_ins[14:0];
            o_res.d       = i_d;
            o_res.written = 1'b0;
            o_res.waddr   = '0;
            o_res.wdata   = '0;
            o_res.fault   = 1'b0;
        end else begin
            o_res.pc      = w_take ? w_a_new : w_pc_inc;
            o_res.a       = w_a_new;
            o_res.d       = i_ins[INS_DEST_D] ? w_r : i_d;
            o_res.written = i_ins[INS_DEST_M];
            o_res.waddr   = i_ins[INS_DEST_M] ? i_a : 15'd0;
            o_res.wdata   = i_ins[INS_DEST_M] ? w_r : 16'd0;
            o_res.fault   = i_ins[INS_DEST_A] & w_neg;
        end
    end

endmodule

`default_nettype wire

// File: design/two_register_cpu_core.sv
// Two-register CPU core. Each input item is one 16-bit instruction; each result item
// reports the PC, A and D after it, any store to the word memory, and the A fault flag.
// After reset the core zeroes its MEM_DEPTH-word memory (32768 by default) one word a cycle,
// and takes no item until that sweep is done. After that it takes a new item only once the
// previous one has left the execute stage: the registered read port first reads the memory
// word at A, then the ALU runs and A, D, PC and memory are written back.
// A finished result waits in an output register while the next item is read.
`default_nettype none

module two_register_cpu_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [15:0] i_instruction,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [14:0]      o_next_pc,
    output logic [14:0]      o_a_value,
    output logic signed [15:0] o_d_value,
    output logic             o_mem_written,
    output logic [14:0]      o_mem_address,
    output logic signed [15:0] o_mem_data,
    output logic             o_a_fault
);
    import trcpu_pkg::*;

    logic        r_ex_valid;
    logic        n_ex_valid;
    logic [15:0] r_ex_ins;
    logic [14:0] r_pc;
    logic [14:0] r_a;
    logic [15:0] r_d;
    logic        r_out_valid;
    logic        n_out_valid;
    t_exec_res   r_out;
    t_exec_res   w_res;
    t_mem_wr     w_wr;
    logic [15:0] w_rd_data;
    logic        w_mem_ready;
    logic        w_in_acc;
    logic        w_ex_fire;
    logic        w_out_acc;

    // Handshake
    assign o_in_stall = r_ex_valid | ~w_mem_ready;
    assign w_in_acc   = i_in_valid & ~o_in_stall;
    assign w_ex_fire  = r_ex_valid & (~r_out_valid | ~i_out_stall);
    assign w_out_acc  = r_out_valid & ~i_out_stall;

    // Word memory; read at A when an item is taken
    trcpu_word_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_in_acc),
        .i_rd_addr (r_a[MEM_AW-1:0]),
        .o_rd_data (w_rd_data),
        .i_wr      (w_wr),
        .o_ready   (w_mem_ready)
    );

    trcpu_exec u_exec (
        .i_ins      (r_ex_ins),
        .i_pc       (r_pc),
        .i_a        (r_a),
        .i_d        (r_d),
        .i_mem_data (w_rd_data),
        .o_res      (w_res)
    );

    // Store at the old A
    always_comb begin
        w_wr.en   = w_ex_fire & w_res.written;
        w_wr.addr = r_a[MEM_AW-1:0];
        w_wr.data = w_res.wdata;
    end

    // Execute stage and output register occupancy
    always_comb begin
        n_ex_valid = r_ex_valid;
        if (w_in_acc) begin
            n_ex_valid = 1'b1;
        end else if (w_ex_fire) begin
            n_ex_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (w_ex_fire) begin
            n_out_valid = 1'b1;
        end else if (w_out_acc) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ex_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pc        <= '0;
            r_a         <= '0;
            r_d         <= '0;
        end else begin
            r_ex_valid  <= n_ex_valid;
            r_out_valid <= n_out_valid;
            if (w_ex_fire) begin
                r_pc <= w_res.pc;
                r_a  <= w_res.a;
                r_d  <= w_res.d;
            end
        end
    end

    // Capture the instruction and the result
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_ex_ins <= i_instruction;
        end
        if (w_ex_fire) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_next_pc     = r_out.pc;
    assign o_a_value     = r_out.a;
    assign o_d_value     = $signed(r_out.d);
    assign o_mem_written = r_out.written;
    assign o_mem_address = r_out.waddr;
    assign o_mem_data    = $signed(r_out.wdata);
    assign o_a_fault     = r_out.fault;

    // An accepted item reaches the execute stage in the next cycle
    a_acc_to_ex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> r_ex_valid)
        else $error("accepted item did not enter execute");

    // No item is in flight while the memory is being cleared
    a_no_ex_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ex_valid |-> w_mem_ready)
        else $error("item in execute during memory clear");

    // An executed item always lands in the output register
    a_ex_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ex_fire |=> r_out_valid)
        else $error("executed item lost");

    // The core's memory store comes only from an executing item
    a_wr_only_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr.en |-> (r_ex_valid && w_mem_ready))
        else $error("memory store without an executing item");

endmodule

`default_nettype wire
